// ===== hdl/tll_pkg.sv =====
`default_nettype none

package tll_pkg;

  localparam int unsigned PosBitsDef = 16;
  localparam int unsigned KwCharsDef = 5;

  localparam int unsigned KindW     = 5;
  localparam int unsigned OffW      = 16;
  localparam int unsigned LenW      = 16;
  localparam int unsigned NumKw     = 8;
  localparam int unsigned KwMaxLen  = 5;
  localparam int unsigned FifoDepth = 4;

  typedef logic [KindW-1:0] kind_t;

  localparam kind_t KIND_EQ    = 5'd10;
  localparam kind_t KIND_EQEQ  = 5'd11;
  localparam kind_t KIND_NUM   = 5'd12;
  localparam kind_t KIND_IDENT = 5'd13;
  localparam kind_t KIND_KW0   = 5'd14;
  localparam kind_t KIND_EOF   = 5'd22;

  localparam logic [7:0] CHAR_EQ = 8'h3d;

  typedef struct packed {
    kind_t           kind;
    logic [OffW-1:0] offset;
    logic [LenW-1:0] length;
    logic            last;
  } result_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } op_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // Single-character operators, kind is the position in the operator list.
  function automatic op_t op_lookup(input logic [7:0] c);
    op_t r;
    r.hit = 1'b1;
    case (c)
      "+":     r.kind = 5'd0;
      "-":     r.kind = 5'd1;
      "*":     r.kind = 5'd2;
      "/":     r.kind = 5'd3;
      ";":     r.kind = 5'd4;
      "(":     r.kind = 5'd5;
      ")":     r.kind = 5'd6;
      "{":     r.kind = 5'd7;
      "}":     r.kind = 5'd8;
      "<":     r.kind = 5'd9;
      default: begin
        r.hit  = 1'b0;
        r.kind = 5'd0;
      end
    endcase
    return r;
  endfunction

  // Keyword text, right aligned: first character in the highest used byte.
  function automatic logic [8*KwMaxLen-1:0] kw_text(input int unsigned k);
    logic [8*KwMaxLen-1:0] t;
    case (k)
      0:       t = (8*KwMaxLen)'("let");
      1:       t = (8*KwMaxLen)'("print");
      2:       t = (8*KwMaxLen)'("if");
      3:       t = (8*KwMaxLen)'("else");
      4:       t = (8*KwMaxLen)'("while");
      5:       t = (8*KwMaxLen)'("true");
      6:       t = (8*KwMaxLen)'("false");
      default: t = (8*KwMaxLen)'("input");
    endcase
    return t;
  endfunction

  function automatic int unsigned kw_len(input int unsigned k);
    int unsigned n;
    case (k)
      0:       n = 3;
      1:       n = 5;
      2:       n = 2;
      3:       n = 4;
      4:       n = 5;
      5:       n = 4;
      6:       n = 5;
      default: n = 5;
    endcase
    return n;
  endfunction

  // Character i of keyword k; only called with i below the keyword length.
  function automatic logic [7:0] kw_byte(input int unsigned k, input int unsigned i);
    logic [8*KwMaxLen-1:0] t;
    int unsigned           sh;
    t  = kw_text(k);
    sh = 8 * (kw_len(k) - 1 - i);
    return t[sh +: 8];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tll_in_if.sv =====
`default_nettype none

interface tll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_source;

  modport source (output valid, output ch, output end_of_source, input ready);
  modport sink   (input valid, input ch, input end_of_source, output ready);
endinterface

`default_nettype wire

// ===== hdl/tll_out_if.sv =====
`default_nettype none

interface tll_out_if import tll_pkg::*; ();
  logic            valid;
  logic            ready;
  kind_t           kind;
  logic [OffW-1:0] offset;
  logic [LenW-1:0] length;
  logic            last;

  modport source (output valid, output kind, output offset, output length, output last,
                  input ready);
  modport sink   (input valid, input kind, input offset, input length, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/toy_language_lexer_unit.sv =====
// Each accepted byte's tokens enter the result queue at that clock edge and are offered
// on out_o once older tokens are taken. One byte per cycle in while in_i.ready is high,
// one token per cycle out while out_o.ready is high; a byte that closes a pending token
// and emits its own pushes two (4-entry queue; in_i.ready needs two free entries).
// Reset (rst_ni low, async): scan mode idle, position/start/length zero, queue empty.
// An end-of-source request also returns the scanner to that state after EOF.
`default_nettype none

module toy_language_lexer_unit import tll_pkg::*; #(
  parameter int unsigned POS_BITS      = PosBitsDef,
  parameter int unsigned KEYWORD_CHARS = KwCharsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tll_in_if.sink     in_i,
  tll_out_if.source  out_o
);

  // Scan modes
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_EQ    = 2'd3;

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = PtrW + 1;

  // ---------------------------------------------------------------------------
  // Scanner state
  // ---------------------------------------------------------------------------
  logic [1:0]          mode_q, mode_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS-1:0] start_q, start_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [7:0]          kbuf_q [KEYWORD_CHARS];   // first identifier bytes, no reset

  logic       in_fire;
  logic [7:0] ch;
  logic       eos;

  assign in_fire = in_i.valid && in_i.ready;
  assign ch      = in_i.ch;
  assign eos     = in_i.end_of_source;

  // ---------------------------------------------------------------------------
  // Keyword match on the buffered identifier. A keyword matches when its length
  // equals the token length and every byte agrees; all keywords fit in the
  // buffer, so longer identifiers never match.
  // ---------------------------------------------------------------------------
  kind_t ident_kind;
  logic  kw_hit;

  always_comb begin
    ident_kind = KIND_IDENT;
    kw_hit     = 1'b0;
    for (int k = NumKw - 1; k >= 0; k--) begin
      kw_hit = (len_q == LenW'(kw_len(k)));
      for (int i = 0; i < KwMaxLen; i++) begin
        if ((i < kw_len(k)) && (kbuf_q[i] != kw_byte(k, i))) begin
          kw_hit = 1'b0;
        end
      end
      if (kw_hit) begin
        ident_kind = KIND_KW0 + KindW'(k);
      end
    end
  end

  // Token the pending mode would emit if closed now
  result_t close_rec;
  logic    close_vld;

  always_comb begin
    close_rec.offset = OffW'(start_q);
    close_rec.length = len_q;
    close_rec.last   = 1'b0;
    close_vld        = 1'b1;
    unique case (mode_q)
      MODE_NUM:   close_rec.kind = KIND_NUM;
      MODE_IDENT: close_rec.kind = ident_kind;
      MODE_EQ: begin
        close_rec.kind   = KIND_EQ;
        close_rec.length = LenW'(1);
      end
      default: begin
        close_rec.kind = KIND_EOF;
        close_vld      = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Per-byte next state and up to two tokens: a closed pending token (pend)
  // followed by the byte's own token or EOF (fresh).
  // ---------------------------------------------------------------------------
  result_t     pend_rec, fresh_rec;
  logic        pend_vld, fresh_vld;
  logic        kbuf_wr_ext, kbuf_wr_first;
  op_t         op;
  logic [LenW-1:0] len_inc;

  assign op      = op_lookup(ch);
  assign len_inc = (len_q != '1) ? len_q + LenW'(1) : len_q;

  always_comb begin
    mode_d        = mode_q;
    pos_d         = pos_q;
    start_d       = start_q;
    len_d         = len_q;
    kbuf_wr_ext   = 1'b0;
    kbuf_wr_first = 1'b0;
    pend_vld      = 1'b0;
    pend_rec      = close_rec;
    fresh_vld     = 1'b0;
    fresh_rec.kind   = op.kind;
    fresh_rec.offset = OffW'(pos_q);
    fresh_rec.length = LenW'(1);
    fresh_rec.last   = 1'b1;

    if (eos) begin
      pend_vld         = close_vld;
      fresh_vld        = 1'b1;
      fresh_rec.kind   = KIND_EOF;
      fresh_rec.length = '0;
      mode_d           = MODE_IDLE;
      pos_d            = '0;
      start_d          = '0;
      len_d            = '0;
    end else begin
      pos_d = pos_q + POS_BITS'(1);
      if ((mode_q == MODE_NUM) && is_digit(ch)) begin
        len_d = len_inc;
      end else if ((mode_q == MODE_IDENT) && (is_alpha(ch) || is_digit(ch))) begin
        kbuf_wr_ext = 1'b1;
        len_d       = len_inc;
      end else if ((mode_q == MODE_EQ) && (ch == CHAR_EQ)) begin
        pend_vld        = 1'b1;
        pend_rec.kind   = KIND_EQEQ;
        pend_rec.length = LenW'(2);
        mode_d          = MODE_IDLE;
      end else begin
        // Close whatever is pending, then scan the byte from idle
        pend_vld = close_vld;
        mode_d   = MODE_IDLE;
        if (op.hit) begin
          fresh_vld = 1'b1;
        end else if (ch == CHAR_EQ) begin
          mode_d  = MODE_EQ;
          start_d = pos_q;
          len_d   = LenW'(1);
        end else if (is_digit(ch)) begin
          mode_d  = MODE_NUM;
          start_d = pos_q;
          len_d   = LenW'(1);
        end else if (is_alpha(ch)) begin
          mode_d        = MODE_IDENT;
          start_d       = pos_q;
          len_d         = LenW'(1);
          kbuf_wr_first = 1'b1;
        end
      end
    end
    pend_rec.last = !fresh_vld;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
    end
  end

  // Identifier bytes: first byte at entry 0, later ones at the current length
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (in_fire && ((kbuf_wr_ext && (len_q == LenW'(i))) || (kbuf_wr_first && (i == 0))))
      begin
        kbuf_q[i] <= ch;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: two writes, one read per cycle
  // ---------------------------------------------------------------------------
  result_t         fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic [1:0]      n_push;
  logic            pop;
  result_t         slot0;
  result_t         head;

  assign n_push = in_fire ? (2'(pend_vld) + 2'(fresh_vld)) : 2'd0;
  assign slot0  = pend_vld ? pend_rec : fresh_rec;
  assign pop    = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= slot0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= fresh_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      cnt_q    <= cnt_q + CntW'(n_push) - CntW'(pop);
    end
  end

  assign head = fifo_q[rd_ptr_q];

  assign in_i.ready   = (cnt_q <= CntW'(FifoDepth - 2));
  assign out_o.valid  = (cnt_q != '0);
  assign out_o.kind   = head.kind;
  assign out_o.offset = head.offset;
  assign out_o.length = head.length;
  assign out_o.last   = head.last;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_eos_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && eos) |=> (mode_q == MODE_IDLE) && (pos_q == '0) && (len_q == '0))
    else $error("scanner not cleared after end of source");

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_IDLE) |-> (len_q != '0))
    else $error("pending token with zero length");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0) |-> (cnt_q + CntW'(n_push) <= CntW'(FifoDepth)))
    else $error("push without room");

  a_eos_pushes_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && eos) |-> (fresh_vld && fresh_rec.last && (fresh_rec.kind == KIND_EOF)))
    else $error("end of source without EOF token");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

// Testbench for toy_language_lexer_unit.
// Bytes go in on in_if one request at a time; every accepted request runs through
// a local model of the scanner, which appends the tokens that byte should cause to
// tokens_due. A separate checker pops the oldest entry on every token taken from
// out_if and compares it field by field. Both sides idle at random, except in the
// calm stretches, and one test holds the token side off long enough that the
// result queue fills and the byte side stalls.
module testbench;
  import tll_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned IDLE_PCT     = 13;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned SHOW_MAX     = 10;
  localparam logic [15:0] LEN_SAT      = 16'hFFFF;
  localparam int unsigned LONG_TOKEN   = 60;  // well past the keyword buffer

  // Scanner modes of the local model.
  typedef enum logic [1:0] {SCAN_IDLE, SCAN_NUM, SCAN_WORD, SCAN_EQ} scan_e;

  // Operator bytes; the token kind is the index in this list.
  localparam byte unsigned OP_CHARS [10] = '{"+", "-", "*", "/", ";", "(", ")", "{", "}", "<"};
  string kw_words [NumKw] = '{"let", "print", "if", "else", "while", "true", "false", "input"};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  tll_in_if  in_if ();
  tll_out_if out_if ();

  toy_language_lexer_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Model state.
  scan_e       mode;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] pos;
  logic [7:0]  word_head [KwCharsDef];

  result_t     tokens_due [$];   // tokens still owed by the block, oldest first
  result_t     step_tokens [$];  // tokens caused by the byte being modeled

  int unsigned items_sent     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          calm           = 1'b0;  // no idling on either side while set
  int unsigned hold_left      = 0;     // cycles the token side still refuses

  // ---------------------------------------------------------------------------
  // Local model of the scanner
  // ---------------------------------------------------------------------------
  function automatic bit is_num(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic bit is_word(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"], "_"};
  endfunction

  function automatic void push_token(input kind_t k, input logic [15:0] off,
                                     input logic [15:0] len);
    result_t t;
    t.kind   = k;
    t.offset = off;
    t.length = len;
    t.last   = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endfunction

  // A word is a keyword only when it is short enough and matches one exactly.
  function automatic kind_t word_kind();
    int  w;
    int  i;
    bit  same;
    if (tok_len > KwCharsDef) return KIND_IDENT;
    for (w = 0; w < NumKw; w++) begin
      if (kw_words[w].len() == tok_len) begin
        same = 1'b1;
        for (i = 0; i < tok_len; i++)
          if (kw_words[w].getc(i) != word_head[i]) same = 1'b0;
        if (same) return kind_t'(KIND_KW0 + w);
      end
    end
    return KIND_IDENT;
  endfunction

  function automatic void close_token();
    case (mode)
      SCAN_NUM:  push_token(KIND_NUM, tok_start, tok_len);
      SCAN_WORD: push_token(word_kind(), tok_start, tok_len);
      SCAN_EQ:   push_token(KIND_EQ, tok_start, 16'd1);
      default: ;
    endcase
    mode = SCAN_IDLE;
  endfunction

  // Byte seen with no token pending.
  function automatic void start_token(input logic [7:0] c);
    int i;
    for (i = 0; i < 10; i++) begin
      if (OP_CHARS[i] == c) begin
        push_token(kind_t'(i), pos, 16'd1);
        return;
      end
    end
    if (c == CHAR_EQ) begin
      mode = SCAN_EQ;
      tok_start = pos;
      tok_len = 16'd1;
    end else if (is_num(c)) begin
      mode = SCAN_NUM;
      tok_start = pos;
      tok_len = 16'd1;
    end else if (is_word(c)) begin
      mode = SCAN_WORD;
      tok_start = pos;
      tok_len = 16'd1;
      word_head[0] = c;
    end
  endfunction

  function automatic void clear_scanner();
    int i;
    mode = SCAN_IDLE;
    tok_start = '0;
    tok_len = '0;
    pos = '0;
    for (i = 0; i < KwCharsDef; i++) word_head[i] = '0;
  endfunction

  function automatic void lex_byte(input logic [7:0] c, input logic eos);
    step_tokens.delete();
    if (eos) begin
      close_token();
      push_token(KIND_EOF, pos, 16'd0);
      clear_scanner();
    end else begin
      if (mode == SCAN_NUM && is_num(c)) begin
        if (tok_len != LEN_SAT) tok_len++;
      end else if (mode == SCAN_WORD && (is_word(c) || is_num(c))) begin
        if (tok_len < KwCharsDef) word_head[tok_len] = c;
        if (tok_len != LEN_SAT) tok_len++;
      end else if (mode == SCAN_EQ && c == CHAR_EQ) begin
        push_token(KIND_EQEQ, tok_start, 16'd2);
        mode = SCAN_IDLE;
      end else begin
        close_token();
        start_token(c);
      end
      pos++;
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) tokens_due.insert(tokens_due.size(), step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte side: one request per call, entered and left just after a falling edge
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic eos);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_if.valid = 1'b0;
        @(negedge clk_i);
      end
    end
    in_if.valid = 1'b1;
    in_if.ch = c;
    in_if.end_of_source = eos;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    lex_byte(c, eos);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s.getc(i), 1'b0);
  endtask

  function automatic logic [7:0] rand_word_char(input bit first);
    int unsigned r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_space();
    case ($urandom_range(0, 3))
      0:       return " ";
      1:       return 8'h09;
      2:       return 8'h0a;
      default: return 8'h0d;
    endcase
  endfunction

  // Token side: ready changes at the falling edge. A hold-off wins over everything.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every token taken is matched against the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_tokens
    result_t want;
    bit      bad;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (tokens_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX)
          $display("%0t: unexpected token kind %0d offset %0d length %0d last %0b",
                   $realtime, out_if.kind, out_if.offset, out_if.length, out_if.last);
      end else begin
        want = tokens_due.pop_front();
        bad = (out_if.kind !== want.kind) || (out_if.offset !== want.offset) ||
              (out_if.length !== want.length) || (out_if.last !== want.last);
        if (bad) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_MAX)
            $display({"%0t: token mismatch: kind %0d/%0d offset %0d/%0d ",
                      "length %0d/%0d last %0b/%0b (expected/actual)"},
                     $realtime, want.kind, out_if.kind, want.offset, out_if.offset,
                     want.length, out_if.length, want.last, out_if.last);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every operator, '==' and a lone '=', a number closed by a letter, a word with
  // '_' and capitals closed by a high unknown byte, a NUL, and a keyword left
  // pending when the source ends (close plus EOF from one request).
  task automatic test_directed_tokens();
    send_text("+-*/;(){}<==");
    send_text("=12a_Z");
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_text("if");
    send_byte(8'hA5, 1'b1);
  endtask

  // Token side refuses for a long stretch while bytes keep coming; each '+' closes
  // the word before it and so owes two tokens, until the full queue stalls the byte side.
  task automatic test_backpressure();
    int i;
    calm = 1'b1;
    hold_left = 80;
    for (i = 0; i < 12; i++) begin
      send_byte("x", 1'b0);
      send_byte("+", 1'b0);
    end
    send_byte(8'h00, 1'b1);
    calm = 1'b0;
  endtask

  // A number and a word much longer than the keyword buffer, run without idling.
  task automatic test_long_tokens();
    int i;
    calm = 1'b1;
    send_byte("1", 1'b0);
    for (i = 1; i < LONG_TOKEN; i++) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
    send_byte(" ", 1'b0);
    send_byte(rand_word_char(1'b1), 1'b0);
    for (i = 1; i < LONG_TOKEN; i++) send_byte(rand_word_char(1'b0), 1'b0);
    send_text(";=");
    send_byte(8'h00, 1'b1);
    calm = 1'b0;
  endtask

  // Mostly well-formed token streams with random content: keywords, near misses
  // of keywords, numbers, words, operators, '=' forms, often run together so one
  // byte closes a token and opens the next. Whitespace, noise bytes and early
  // ends of source are mixed in.
  task automatic test_random_stream();
    int unsigned first_item;
    int unsigned pick;
    int unsigned n;
    int unsigned i;
    int unsigned at;
    string       w;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        send_byte(OP_CHARS[$urandom_range(0, 9)], 1'b0);
      end else if (pick < 23) begin
        send_byte(CHAR_EQ, 1'b0);
        if ($urandom_range(0, 1)) send_byte(CHAR_EQ, 1'b0);
      end else if (pick < 35) begin
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (pick < 47) begin
        send_text(kw_words[$urandom_range(0, NumKw - 1)]);
      end else if (pick < 57) begin
        // near miss: cut short, one extra char, or one letter's case flipped
        w = kw_words[$urandom_range(0, NumKw - 1)];
        case ($urandom_range(0, 2))
          0: send_text(w.substr(0, w.len() - 2));
          1: begin
            send_text(w);
            send_byte(rand_word_char(1'b0), 1'b0);
          end
          default: begin
            at = $urandom_range(0, w.len() - 1);
            w.putc(at, w.getc(at) ^ 8'h20);
            send_text(w);
          end
        endcase
      end else if (pick < 68) begin
        n = $urandom_range(1, 9);
        send_byte(rand_word_char(1'b1), 1'b0);
        for (i = 1; i < n; i++) send_byte(rand_word_char(1'b0), 1'b0);
      end else if (pick < 80) begin
        send_byte(rand_space(), 1'b0);
      end else if (pick < 96) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    send_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  initial begin
    clear_scanner();
    in_if.valid = 1'b0;
    in_if.ch = '0;
    in_if.end_of_source = 1'b0;
    out_if.ready = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_tokens();
    test_backpressure();
    test_long_tokens();
    test_random_stream();
    in_if.valid = 1'b0;

    // Let the block hand over whatever it still owes, then keep the checker running
    // in case something extra shows up.
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/tll_pkg.sv
hdl/tll_in_if.sv
hdl/tll_out_if.sv
hdl/toy_language_lexer_unit.sv
test/testbench.sv
